FILE: rtl/core/tvs_pkg.sv
// shared types and constants of the trilinear volume sampler
// used by trilinear_volume_sampler_top, tvs_vmem and tvs_lerp; no dependencies
package tvs_pkg;

  localparam int unsigned MAX_DIM_DEF     = 32;
  localparam int unsigned VOXEL_COUNT_DEF = 32768;

  localparam int unsigned SIZE_W     = 6;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned COORD_W    = 17;
  localparam logic [COORD_W-1:0] COORD_ONE = 17'h10000;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned HALF_TEXEL = 32768;
  localparam int unsigned VADDR_W    = 15;
  localparam int unsigned VOXEL_W    = 8;
  localparam int unsigned SAMPLE_W   = 16;

  localparam int unsigned NBR_COUNT  = 8;
  localparam int unsigned K_W        = $clog2(NBR_COUNT);
  localparam logic [K_W-1:0] K_LAST  = K_W'(NBR_COUNT - 1);

  localparam int unsigned OUT_DEPTH  = 4;
  localparam int unsigned PTR_W      = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_W      = $clog2(OUT_DEPTH + 1);

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [FRAC_W-1:0] x;
    logic [FRAC_W-1:0] y;
    logic [FRAC_W-1:0] z;
  } frac_t;

endpackage

FILE: rtl/core/tvs_vmem.sv
// single-port voxel memory with registered read data
// depends on tvs_pkg for the voxel width
module tvs_vmem #(
  parameter int unsigned DEPTH = tvs_pkg::VOXEL_COUNT_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               addr_i,
  input  logic [tvs_pkg::VOXEL_W-1:0] wdata_i,
  output logic [tvs_pkg::VOXEL_W-1:0] rdata_o
);
  import tvs_pkg::*;

  logic [VOXEL_W-1:0] mem_q [DEPTH];
  logic [VOXEL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/tvs_lerp.sv
// registered truncating linear interpolation a + ((b - a) * f) >> 16 in Q8.8
// depends on tvs_pkg for widths
module tvs_lerp (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [tvs_pkg::SAMPLE_W-1:0] a_i,
  input  logic [tvs_pkg::SAMPLE_W-1:0] b_i,
  input  logic [tvs_pkg::FRAC_W-1:0]   f_i,
  output logic [tvs_pkg::SAMPLE_W-1:0] y_o
);
  import tvs_pkg::*;

  localparam int unsigned D_W = SAMPLE_W + 1;
  localparam int unsigned P_W = D_W + FRAC_W + 1;
  localparam int unsigned S_W = P_W - FRAC_W;

  logic signed [D_W-1:0]      diff;
  logic signed [FRAC_W:0]     f_s;
  logic signed [P_W-1:0]      prod;
  logic signed [S_W-1:0]      sum;
  logic        [SAMPLE_W-1:0] y_d;
  logic        [SAMPLE_W-1:0] y_q;

  always_comb begin
    diff = $signed({1'b0, b_i}) - $signed({1'b0, a_i});
    f_s  = $signed({1'b0, f_i});
    prod = P_W'(diff) * P_W'(f_s);
    sum  = $signed(S_W'({1'b0, a_i})) + prod[P_W-1:FRAC_W];
    y_d  = sum[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

FILE: rtl/core/trilinear_volume_sampler_top.sv
// trilinear volume sampler: voxel store, neighbor read sequencer and lerp tree
// depends on tvs_pkg, tvs_vmem and tvs_lerp
//
//   channel | handshake                | payload
//   --------+--------------------------+-----------------------------------------
//   in      | in_valid_i / in_ready_o  | func_i voxel_addr_i voxel_value_i coord_*
//   cfg     | cfg_valid_i / cfg_ready_o| cfg_index_i cfg_data_i
//   out     | out_valid_o / out_ready_i| sample_value_o
//
// a write transaction makes a single voxel memory port access, a sample
// transaction one port access per neighbor voxel
// a sample result reaches the result queue through the address stages, the memory read and the z, y and x lerps
// reset clears control and sets all extents to 32; the voxel memory is not cleared
// a 4-entry result queue with credit counting holds the first read of a sample
// while four samples are outstanding
module trilinear_volume_sampler_top #(
  parameter int unsigned MAX_DIM     = tvs_pkg::MAX_DIM_DEF,
  parameter int unsigned VOXEL_COUNT = tvs_pkg::VOXEL_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [tvs_pkg::VADDR_W-1:0]   voxel_addr_i,
  input  logic [tvs_pkg::VOXEL_W-1:0]   voxel_value_i,
  input  logic [tvs_pkg::COORD_W-1:0]   coord_x_i,
  input  logic [tvs_pkg::COORD_W-1:0]   coord_y_i,
  input  logic [tvs_pkg::COORD_W-1:0]   coord_z_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tvs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tvs_pkg::SIZE_W-1:0]    cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tvs_pkg::SAMPLE_W-1:0]  sample_value_o
);
  import tvs_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_DIM);
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned HI_W  = IDX_W + 1;
  localparam int unsigned P_W   = COORD_W + DIM_W;
  localparam int unsigned ROW_W = IDX_W + DIM_W;
  localparam int unsigned LIN_W = ROW_W + DIM_W;
  localparam int unsigned AW    = $clog2(VOXEL_COUNT);

  // configuration
  logic [SIZE_W-1:0] size_q [3];
  logic [DIM_W-1:0]  eff_size [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q[0] <= SIZE_RESET;
      size_q[1] <= SIZE_RESET;
      size_q[2] <= SIZE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SIZE_X: size_q[0] <= cfg_data_i;
        REG_SIZE_Y: size_q[1] <= cfg_data_i;
        REG_SIZE_Z: size_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-axis floor, ceil and fraction
  logic [COORD_W-1:0] coord [3];
  logic [IDX_W-1:0]   axis_lo [3];
  logic [IDX_W-1:0]   axis_hi [3];
  logic [FRAC_W-1:0]  axis_frac [3];

  assign coord[0] = coord_x_i;
  assign coord[1] = coord_y_i;
  assign coord[2] = coord_z_i;

  for (genvar g = 0; g < 3; g++) begin : g_axis
    logic [DIM_W-1:0]   eff;
    logic [COORD_W-1:0] c_sat;
    logic [P_W-1:0]     p;
    logic [P_W-1:0]     ps;
    logic [IDX_W-1:0]   lo;
    logic [HI_W-1:0]    hi_w;
    logic [IDX_W-1:0]   hi;

    always_comb begin
      if (size_q[g] == '0) begin
        eff = DIM_W'(1);
      end else if (32'(size_q[g]) > MAX_DIM) begin
        eff = DIM_W'(MAX_DIM);
      end else begin
        eff = DIM_W'(size_q[g]);
      end
      c_sat = (coord[g] > COORD_ONE) ? COORD_ONE : coord[g];
      p     = P_W'(c_sat) * P_W'(eff);
      ps    = (p > P_W'(HALF_TEXEL)) ? p - P_W'(HALF_TEXEL) : '0;
      lo    = IDX_W'(ps[P_W-1:FRAC_W]);
      hi_w  = {1'b0, lo} + HI_W'(ps[FRAC_W-1:0] != '0);
      hi    = (hi_w >= HI_W'(eff)) ? IDX_W'(hi_w - 1'b1) : IDX_W'(hi_w);
    end

    assign eff_size[g]  = eff;
    assign axis_lo[g]   = lo;
    assign axis_hi[g]   = hi;
    assign axis_frac[g] = ps[FRAC_W-1:0];
  end

  // issue stage: one memory operation per cycle, unless a sample's first read waits for a credit
  logic             s1_valid_q, s1_valid_d;
  func_e            s1_func_q;
  logic [K_W-1:0]   s1_k_q, s1_k_d;
  logic [AW-1:0]    s1_waddr_q;
  logic [VOXEL_W-1:0] s1_wdata_q;
  logic [IDX_W-1:0] s1_lo_q [3];
  logic [IDX_W-1:0] s1_hi_q [3];
  frac_t            s1_frac_q;

  logic [CNT_W-1:0] inflight_q, inflight_d;
  logic             s1_sample, credit_ok, issue, issue_last, start, in_accept, out_pop;

  always_comb begin
    s1_sample  = (s1_func_q == FUNC_SAMPLE);
    credit_ok  = (inflight_q < CNT_W'(OUT_DEPTH));
    issue      = s1_valid_q && (!s1_sample || (s1_k_q != '0) || credit_ok);
    issue_last = s1_valid_q && (!s1_sample || (s1_k_q == K_LAST));
    start      = issue && s1_sample && (s1_k_q == '0);
    in_ready_o = !s1_valid_q || issue_last;
    in_accept  = in_valid_i && in_ready_o;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_k_d     = s1_k_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
      s1_k_d     = '0;
    end else begin
      if (issue_last) begin
        s1_valid_d = 1'b0;
      end
      if (issue && s1_sample) begin
        s1_k_d = s1_k_q + 1'b1;
      end
    end
    inflight_d = inflight_q + CNT_W'(start) - CNT_W'(out_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_k_q     <= '0;
      s1_func_q  <= FUNC_WRITE;
      inflight_q <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_k_q     <= s1_k_d;
      inflight_q <= inflight_d;
      if (in_accept) begin
        s1_func_q <= func_e'(func_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_waddr_q  <= AW'(voxel_addr_i);
      s1_wdata_q  <= voxel_value_i;
      s1_lo_q     <= axis_lo;
      s1_hi_q     <= axis_hi;
      s1_frac_q.x <= axis_frac[0];
      s1_frac_q.y <= axis_frac[1];
      s1_frac_q.z <= axis_frac[2];
    end
  end

  // address stage 1: row index z*sy + y
  logic [IDX_W-1:0] sel_x, sel_y, sel_z;
  logic [ROW_W-1:0] row_d;

  always_comb begin
    sel_x = s1_k_q[2] ? s1_hi_q[0] : s1_lo_q[0];
    sel_y = s1_k_q[1] ? s1_hi_q[1] : s1_lo_q[1];
    sel_z = s1_k_q[0] ? s1_hi_q[2] : s1_lo_q[2];
    row_d = ROW_W'(sel_z) * ROW_W'(eff_size[1]) + ROW_W'(sel_y);
  end

  logic               a1_valid_q;
  logic               a1_wr_q;
  logic [ROW_W-1:0]   a1_row_q;
  logic [IDX_W-1:0]   a1_x_q;
  logic [AW-1:0]      a1_waddr_q;
  logic [VOXEL_W-1:0] a1_wdata_q;
  logic [K_W-1:0]     a1_k_q;
  frac_t              a1_frac_q;

  // address stage 2: linear address row*sx + x
  logic [LIN_W-1:0]   lin_d;
  logic               a2_valid_q;
  logic               a2_wr_q;
  logic [AW-1:0]      a2_addr_q;
  logic [VOXEL_W-1:0] a2_wdata_q;
  logic [K_W-1:0]     a2_k_q;
  frac_t              a2_frac_q;

  assign lin_d = LIN_W'(a1_row_q) * LIN_W'(eff_size[0]) + LIN_W'(a1_x_q);

  // read data stage
  logic               r_valid_q;
  logic [K_W-1:0]     r_k_q;
  frac_t              r_frac_q;
  logic [VOXEL_W-1:0] rdata;
  logic [SAMPLE_W-1:0] vox;

  // lerp tree stages
  logic                z_en, y_en, x_en;
  logic                z_valid_q, y_valid_q, x_valid_q;
  logic [1:0]          z_idx_q;
  logic                y_idx_q;
  frac_t               z_frac_q;
  logic [FRAC_W-1:0]   y_fx_q;
  logic [SAMPLE_W-1:0] hold_z_q, hold_y_q, hold_x_q;
  logic [SAMPLE_W-1:0] z_res, y_res, x_res;

  assign vox  = {rdata, {(SAMPLE_W - VOXEL_W){1'b0}}};
  assign z_en = r_valid_q && r_k_q[0];
  assign y_en = z_valid_q && z_idx_q[0];
  assign x_en = y_valid_q && y_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_valid_q <= 1'b0;
      a2_valid_q <= 1'b0;
      r_valid_q  <= 1'b0;
      z_valid_q  <= 1'b0;
      y_valid_q  <= 1'b0;
      x_valid_q  <= 1'b0;
    end else begin
      a1_valid_q <= issue;
      a2_valid_q <= a1_valid_q;
      r_valid_q  <= a2_valid_q && !a2_wr_q;
      z_valid_q  <= z_en;
      y_valid_q  <= y_en;
      x_valid_q  <= x_en;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_wr_q    <= !s1_sample;
    a1_row_q   <= row_d;
    a1_x_q     <= sel_x;
    a1_waddr_q <= s1_waddr_q;
    a1_wdata_q <= s1_wdata_q;
    a1_k_q     <= s1_k_q;
    a1_frac_q  <= s1_frac_q;

    a2_wr_q    <= a1_wr_q;
    a2_addr_q  <= a1_wr_q ? a1_waddr_q : AW'(lin_d);
    a2_wdata_q <= a1_wdata_q;
    a2_k_q     <= a1_k_q;
    a2_frac_q  <= a1_frac_q;

    r_k_q      <= a2_k_q;
    r_frac_q   <= a2_frac_q;

    z_idx_q    <= r_k_q[2:1];
    z_frac_q   <= r_frac_q;
    y_idx_q    <= z_idx_q[1];
    y_fx_q     <= z_frac_q.x;

    if (r_valid_q && !r_k_q[0]) begin
      hold_z_q <= vox;
    end
    if (z_valid_q && !z_idx_q[0]) begin
      hold_y_q <= z_res;
    end
    if (y_valid_q && !y_idx_q) begin
      hold_x_q <= y_res;
    end
  end

  tvs_vmem #(
    .DEPTH (VOXEL_COUNT),
    .AW    (AW)
  ) u_vmem (
    .clk_i   (clk_i),
    .en_i    (a2_valid_q),
    .we_i    (a2_wr_q),
    .addr_i  (a2_addr_q),
    .wdata_i (a2_wdata_q),
    .rdata_o (rdata)
  );

  tvs_lerp u_lerp_z (
    .clk_i (clk_i),
    .en_i  (z_en),
    .a_i   (hold_z_q),
    .b_i   (vox),
    .f_i   (r_frac_q.z),
    .y_o   (z_res)
  );

  tvs_lerp u_lerp_y (
    .clk_i (clk_i),
    .en_i  (y_en),
    .a_i   (hold_y_q),
    .b_i   (z_res),
    .f_i   (z_frac_q.y),
    .y_o   (y_res)
  );

  tvs_lerp u_lerp_x (
    .clk_i (clk_i),
    .en_i  (x_en),
    .a_i   (hold_x_q),
    .b_i   (y_res),
    .f_i   (y_fx_q),
    .y_o   (x_res)
  );

  // result queue
  logic [SAMPLE_W-1:0] oq_q [OUT_DEPTH];
  logic [PTR_W-1:0]    oq_wr_q, oq_rd_q;
  logic [CNT_W-1:0]    oq_cnt_q;

  assign out_valid_o    = (oq_cnt_q != '0);
  assign out_pop        = out_valid_o && out_ready_i;
  assign sample_value_o = oq_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (x_valid_q) begin
        oq_wr_q <= oq_wr_q + 1'b1;
      end
      if (out_pop) begin
        oq_rd_q <= oq_rd_q + 1'b1;
      end
      oq_cnt_q <= oq_cnt_q + CNT_W'(x_valid_q) - CNT_W'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (x_valid_q) begin
      oq_q[oq_wr_q] <= x_res;
    end
  end

endmodule

FILE: tb/testbench.sv
// self-checking testbench for trilinear_volume_sampler_top: voxel writes and trilinear samples
// against an in-bench predictor with its own voxel mirror; depends on tvs_pkg and the rtl
module testbench;
  import tvs_pkg::*;

  localparam int RESET_CYCLES      = 7;
  localparam int DRAIN_CYCLES      = 32;
  localparam int HOLD_CYCLES       = 150;
  localparam int WATCHDOG_LIMIT    = 4000;
  localparam int RANDOM_PHASES     = 10;
  localparam int SAMPLES_PER_PHASE = 10;
  localparam int PRESSURE_SAMPLES  = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct packed {
    logic [5:0]        lo;
    logic [5:0]        hi;
    logic [FRAC_W-1:0] frac;
  } axis_t;

  typedef struct packed {
    logic [7:0][VADDR_W-1:0] addr;
    logic [FRAC_W-1:0]       fx;
    logic [FRAC_W-1:0]       fy;
    logic [FRAC_W-1:0]       fz;
  } corners_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  func_i;
  logic [VADDR_W-1:0]    voxel_addr_i;
  logic [VOXEL_W-1:0]    voxel_value_i;
  logic [COORD_W-1:0]    coord_x_i;
  logic [COORD_W-1:0]    coord_y_i;
  logic [COORD_W-1:0]    coord_z_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [SIZE_W-1:0]     cfg_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [SAMPLE_W-1:0]   sample_value_o;

  logic [VOXEL_W-1:0]    voxel_mem [VOXEL_COUNT_DEF];
  bit                    voxel_written [VOXEL_COUNT_DEF];
  logic [SIZE_W-1:0]     size_x_q;
  logic [SIZE_W-1:0]     size_y_q;
  logic [SIZE_W-1:0]     size_z_q;
  logic [SAMPLE_W-1:0]   pending_samples [$];
  logic [SAMPLE_W-1:0]   expected_now;

  int fail_count;
  int samples_checked;
  int writes_sent;
  int settings_used;
  int quiet_cycles;
  bit no_idle;
  bit hold_results;

  trilinear_volume_sampler_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .voxel_addr_i   (voxel_addr_i),
    .voxel_value_i  (voxel_value_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .coord_z_i      (coord_z_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_value_o (sample_value_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_extent(logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_DIM_DEF) return MAX_DIM_DEF;
    return s;
  endfunction

  function automatic axis_t split_axis(logic [COORD_W-1:0] coord, int unsigned ext);
    axis_t           r;
    longint unsigned p;
    int unsigned     lo;
    int unsigned     hi;
    p = (coord > COORD_ONE) ? 64'(COORD_ONE) : 64'(coord);
    p = p * ext;
    p = (p > HALF_TEXEL) ? p - HALF_TEXEL : 64'd0;
    lo = 32'(p >> FRAC_W);
    r.frac = p[FRAC_W-1:0];
    hi = lo + ((r.frac != 0) ? 1 : 0);
    if (hi >= ext) hi = hi - 1;
    r.lo = lo[5:0];
    r.hi = hi[5:0];
    return r;
  endfunction

  function automatic corners_t locate_corners(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                              logic [COORD_W-1:0] cz);
    corners_t    c;
    axis_t       ax;
    axis_t       ay;
    axis_t       az;
    int unsigned sx;
    int unsigned sy;
    int unsigned sz;
    int unsigned x;
    int unsigned y;
    int unsigned z;
    sx = clamp_extent(size_x_q);
    sy = clamp_extent(size_y_q);
    sz = clamp_extent(size_z_q);
    ax = split_axis(cx, sx);
    ay = split_axis(cy, sy);
    az = split_axis(cz, sz);
    for (int k = 0; k < NBR_COUNT; k++) begin
      x = k[2] ? ax.hi : ax.lo;
      y = k[1] ? ay.hi : ay.lo;
      z = k[0] ? az.hi : az.lo;
      c.addr[k] = VADDR_W'(((z * sy + y) * sx + x) % VOXEL_COUNT_DEF);
    end
    c.fx = ax.frac;
    c.fy = ay.frac;
    c.fz = az.frac;
    return c;
  endfunction

  function automatic logic [SAMPLE_W-1:0] blend(logic [15:0] a, logic [15:0] b,
                                                logic [FRAC_W-1:0] f);
    longint unsigned s;
    s = 64'(a) * (64'd65536 - 64'(f)) + 64'(b) * 64'(f);
    return SAMPLE_W'(s >> 16);
  endfunction

  function automatic logic [SAMPLE_W-1:0] trilinear_sample(logic [COORD_W-1:0] cx,
                                                           logic [COORD_W-1:0] cy,
                                                           logic [COORD_W-1:0] cz);
    corners_t         c;
    logic [7:0][15:0] v;
    logic [15:0]      i1;
    logic [15:0]      i2;
    logic [15:0]      j1;
    logic [15:0]      j2;
    logic [15:0]      w1;
    logic [15:0]      w2;
    c = locate_corners(cx, cy, cz);
    for (int k = 0; k < NBR_COUNT; k++) v[k] = {voxel_mem[c.addr[k]], 8'h00};
    i1 = blend(v[0], v[1], c.fz);
    i2 = blend(v[2], v[3], c.fz);
    j1 = blend(v[4], v[5], c.fz);
    j2 = blend(v[6], v[7], c.fz);
    w1 = blend(i1, i2, c.fy);
    w2 = blend(j1, j2, c.fy);
    return blend(w1, w2, c.fx);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord(int unsigned ext);
    int          r;
    int unsigned k;
    r = $urandom_range(0, 99);
    if (r < 45) return COORD_W'($urandom_range(0, 65536));
    if (r < 60) begin
      k = $urandom_range(0, ext - 1);
      return COORD_W'(((2 * k + 1) * HALF_TEXEL) / ext);
    end
    if (r < 75) return $urandom_range(0, 1) ? COORD_ONE : '0;
    if (r < 85) return COORD_W'($urandom_range(65537, 131071));
    return COORD_W'($urandom_range(0, 131071));
  endfunction

  task automatic send_item(input func_e op, input logic [VADDR_W-1:0] addr,
                           input logic [VOXEL_W-1:0] val, input logic [COORD_W-1:0] cx,
                           input logic [COORD_W-1:0] cy, input logic [COORD_W-1:0] cz);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= op;
    voxel_addr_i  <= addr;
    voxel_value_i <= val;
    coord_x_i     <= cx;
    coord_y_i     <= cy;
    coord_z_i     <= cz;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == FUNC_WRITE) begin
      voxel_mem[addr] = val;
      voxel_written[addr] = 1'b1;
      writes_sent++;
    end else begin
      pending_samples.push_back(trilinear_sample(cx, cy, cz));
    end
  endtask

  task automatic write_voxel(input logic [VADDR_W-1:0] addr, input logic [VOXEL_W-1:0] val);
    send_item(FUNC_WRITE, addr, val, COORD_W'($urandom_range(0, 131071)),
              COORD_W'($urandom_range(0, 131071)), COORD_W'($urandom_range(0, 131071)));
  endtask

  // neighbors never written get a value first
  task automatic sample_at(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                           input logic [COORD_W-1:0] cz);
    corners_t c;
    c = locate_corners(cx, cy, cz);
    for (int k = 0; k < NBR_COUNT; k++) begin
      if (!voxel_written[c.addr[k]]) write_voxel(c.addr[k], VOXEL_W'($urandom_range(0, 255)));
    end
    send_item(FUNC_SAMPLE, VADDR_W'($urandom_range(0, 32767)), VOXEL_W'($urandom_range(0, 255)),
              cx, cy, cz);
  endtask

  task automatic sample_random();
    sample_at(rand_coord(clamp_extent(size_x_q)), rand_coord(clamp_extent(size_y_q)),
              rand_coord(clamp_extent(size_z_q)));
  endtask

  task automatic fill_volume();
    int unsigned count;
    count = clamp_extent(size_x_q) * clamp_extent(size_y_q) * clamp_extent(size_z_q);
    for (int unsigned a = 0; a < count; a++) begin
      write_voxel(VADDR_W'(a), VOXEL_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic begin_phase();
    release_input();
    wait_idle();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SIZE_X: size_x_q = data;
      REG_SIZE_Y: size_y_q = data;
      REG_SIZE_Z: size_z_q = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_extents(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                             input logic [SIZE_W-1:0] sz);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    settings_used++;
  endtask

  function automatic logic [SIZE_W-1:0] rand_extent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return SIZE_W'($urandom_range(1, 6));
    if (r < 70) return SIZE_W'($urandom_range(7, 31));
    if (r < 80) return SIZE_W'(32);
    if (r < 90) return SIZE_W'($urandom_range(33, 63));
    return SIZE_W'($urandom_range(0, 1));
  endfunction

  // reset extents of 32: corners of the volume and coordinates past 1.0
  task automatic test_volume_corners();
    settings_used++;
    write_voxel('0, 8'h00);
    write_voxel(VADDR_W'(VOXEL_COUNT_DEF - 1), 8'hff);
    sample_at('0, '0, '0);
    sample_at(COORD_ONE, COORD_ONE, COORD_ONE);
    write_voxel('0, 8'hff);
    sample_at(17'h1ffff, 17'h1ffff, 17'h1ffff);
    sample_at('0, '0, '0);
  endtask

  task automatic test_unit_cube();
    begin_phase();
    set_extents(6'd2, 6'd2, 6'd2);
    fill_volume();
    sample_at(17'd32768, 17'd32768, 17'd32768);
    sample_at(17'd16384, 17'd16384, 17'd16384);
    sample_at(17'd49152, 17'd16384, 17'd32768);
    sample_at(COORD_ONE, '0, 17'd40000);
  endtask

  // zero extent acts as one, oversize extent saturates, unused index is ignored
  task automatic test_extent_limits();
    begin_phase();
    set_extents(6'd0, 6'd63, 6'd1);
    write_reg(CFG_IDX_UNUSED, 6'd5);
    sample_at(COORD_ONE, 17'd33000, 17'h1ffff);
    sample_at('0, 17'd40000, '0);
    sample_at(17'd70000, COORD_ONE, 17'd12345);
  endtask

  task automatic test_random_mix();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      begin_phase();
      set_extents(rand_extent(), rand_extent(), rand_extent());
      if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_UNUSED, SIZE_W'($urandom_range(0, 63)));
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          write_voxel(VADDR_W'($urandom_range(0, 32767)), VOXEL_W'($urandom_range(0, 255)));
        end
        sample_random();
      end
      no_idle = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    begin_phase();
    set_extents(6'd3, 6'd4, 6'd2);
    fill_volume();
    hold_results = 1'b1;
    no_idle = 1'b1;
    for (int n = 0; n < PRESSURE_SAMPLES; n++) sample_random();
    no_idle = 1'b0;
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_results = 1'b0;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        out_ready_i <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        $display("%0t unexpected sample: expected none, actual %0d", $time, sample_value_o);
        fail_count++;
      end else begin
        expected_now = pending_samples.pop_front();
        if (sample_value_o !== expected_now) begin
          $display("%0t sample_value mismatch: expected %0d, actual %0d", $time, expected_now,
                   sample_value_o);
          fail_count++;
        end
        samples_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = FUNC_WRITE;
    voxel_addr_i  = '0;
    voxel_value_i = '0;
    coord_x_i     = '0;
    coord_y_i     = '0;
    coord_z_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_SIZE_X;
    cfg_data_i    = '0;
    quiet_cycles  = 0;
    size_x_q      = SIZE_RESET;
    size_y_q      = SIZE_RESET;
    size_z_q      = SIZE_RESET;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_volume_corners();
    test_unit_cube();
    test_extent_limits();
    test_backpressure();
    test_random_mix();

    release_input();
    wait_idle();
    if (pending_samples.size() != 0) begin
      $display("%0t %0d expected samples never arrived", $time, pending_samples.size());
      fail_count++;
    end
    $display("covered %0d samples and %0d voxel writes over %0d extent settings,", samples_checked,
             writes_sent, settings_used);
    $display("including extents 0 and 63, coordinates past 1.0 and a full output stall");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
